// ----- hw/rtl/modular_multiply_64_defines.svh -----
// Assertion macros used by the checker file.
`ifndef MODULAR_MULTIPLY_64_DEFINES_SVH
`define MODULAR_MULTIPLY_64_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent (or after a ## delay inside it).
`define MM64_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> cons) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MM64_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/mm64_pkg.sv -----
package mm64_pkg;

   localparam int FIELD_BITS = 64;
   localparam int PC_BITS    = 3;

   typedef logic [PC_BITS-1:0] pc_type;
   typedef logic [2:0]         op_type;
   typedef logic [1:0]         jump_type;

   // datapath operations
   localparam op_type OP_NOP    = 3'd0;
   localparam op_type OP_LOAD   = 3'd1;
   localparam op_type OP_REDUCE = 3'd2;
   localparam op_type OP_SETUP  = 3'd3;
   localparam op_type OP_MULT   = 3'd4;
   localparam op_type OP_EMIT   = 3'd5;

   // sequencing
   localparam jump_type JMP_NEXT   = 2'd0;
   localparam jump_type JMP_ALWAYS = 2'd1;
   localparam jump_type JMP_LOOP   = 2'd2;
   localparam jump_type JMP_WAIT   = 2'd3;

   // program steps
   localparam pc_type STEP_IDLE   = 3'd0;
   localparam pc_type STEP_REDUCE = 3'd1;
   localparam pc_type STEP_SETUP  = 3'd2;
   localparam pc_type STEP_MULT   = 3'd3;
   localparam pc_type STEP_EMIT   = 3'd4;

   typedef struct packed {
      op_type   op;
      jump_type jump;
      pc_type   target;
   } ctrl_word_type;

   // microprogram ROM
   function automatic ctrl_word_type mm64_rom(input pc_type pc);
      ctrl_word_type cw;
      case (pc)
         STEP_IDLE:   cw = '{op: OP_LOAD,   jump: JMP_WAIT,   target: STEP_IDLE};
         STEP_REDUCE: cw = '{op: OP_REDUCE, jump: JMP_LOOP,   target: STEP_REDUCE};
         STEP_SETUP:  cw = '{op: OP_SETUP,  jump: JMP_NEXT,   target: STEP_IDLE};
         STEP_MULT:   cw = '{op: OP_MULT,   jump: JMP_LOOP,   target: STEP_MULT};
         STEP_EMIT:   cw = '{op: OP_EMIT,   jump: JMP_ALWAYS, target: STEP_IDLE};
         default:     cw = '{op: OP_NOP,    jump: JMP_ALWAYS, target: STEP_IDLE};
      endcase
      return cw;
   endfunction

endpackage

// ----- hw/rtl/mm64_csub.sv -----
// Conditional subtract: res_out = sum_in >= mod_in ? sum_in - mod_in : sum_in.
module mm64_csub #(
   parameter int WIDTH = 64
) (
   input  logic [WIDTH:0]   sum_in,
   input  logic [WIDTH-1:0] mod_in,
   output logic [WIDTH-1:0] res_out
);

   logic [WIDTH+1:0] diff;

   assign diff    = {1'b0, sum_in} - {2'b00, mod_in};
   assign res_out = diff[WIDTH+1] ? sum_in[WIDTH-1:0] : diff[WIDTH-1:0];

endmodule

// ----- hw/rtl/modular_multiply_64.sv -----
// Modular multiplier: rsp_product_mod = (req_factor_a * req_factor_b) mod req_modulus on
// WORD_BITS-bit unsigned words (input bits at and above WORD_BITS are ignored). Pulse start
// while busy is low to hand in one beat; busy rises on the next cycle and stays high until
// the result is ready. From the accepting edge each item runs through bit-serial reduction
// of both factors, one setup step, double-and-add, a step to register the result, and the
// result cycle itself, during which busy is already low so the next beat may be accepted.
// The result shows for exactly one cycle with rsp_valid high and is not held: the receiver
// must take it then, since the block cannot be stalled. A modulus of zero or one returns
// zero.
module modular_multiply_64 #(
   parameter int WORD_BITS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [mm64_pkg::FIELD_BITS-1:0]   req_factor_a,
   input  logic [mm64_pkg::FIELD_BITS-1:0]   req_factor_b,
   input  logic [mm64_pkg::FIELD_BITS-1:0]   req_modulus,
   output logic                              rsp_valid,
   output logic [mm64_pkg::FIELD_BITS-1:0]   rsp_product_mod
);

   localparam int CNT_BITS = $clog2(WORD_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

   // ---------------------------------------------------------------------------------------
   // Sequencer: program counter, loop counter and the control word read from the ROM.
   // ---------------------------------------------------------------------------------------
   mm64_pkg::pc_type        pc_ff, pc_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   mm64_pkg::ctrl_word_type cw;
   logic                    accept;
   logic                    cnt_last;

   // ---------------------------------------------------------------------------------------
   // Datapath registers. opa/opb first hold the dividends being shifted out MSB first during
   // reduction, then the multiplicand (doubled each step) and the multiplier (shifted right).
   // ---------------------------------------------------------------------------------------
   logic [WORD_BITS-1:0]    opa_ff, opa_in;
   logic [WORD_BITS-1:0]    opb_ff, opb_in;
   logic [WORD_BITS-1:0]    rem_a_ff, rem_a_in;
   logic [WORD_BITS-1:0]    rem_b_ff, rem_b_in;
   logic [WORD_BITS-1:0]    acc_ff, acc_in;
   logic [WORD_BITS-1:0]    mod_ff, mod_in;
   logic                    tiny_ff, tiny_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0]    rsp_prod_ff, rsp_prod_in;

   // Compare-and-subtract results
   logic [WORD_BITS-1:0]    rem_a_nx, rem_b_nx, acc_nx, dbl_nx;
   logic [WORD_BITS:0]      acc_sum;

   assign cw       = mm64_pkg::mm64_rom(pc_ff);
   assign busy     = (pc_ff != mm64_pkg::STEP_IDLE);
   assign accept   = start && !busy;
   assign cnt_last = (cnt_ff == CNT_LAST);

   // Next program step from the control word's jump field.
   always_comb begin
      pc_in = pc_ff + mm64_pkg::PC_BITS'(1);
      case (cw.jump)
         mm64_pkg::JMP_NEXT:   pc_in = pc_ff + mm64_pkg::PC_BITS'(1);
         mm64_pkg::JMP_ALWAYS: pc_in = cw.target;
         mm64_pkg::JMP_LOOP:   if (!cnt_last) pc_in = cw.target;
         mm64_pkg::JMP_WAIT:   if (!accept) pc_in = cw.target;
         default:              pc_in = mm64_pkg::STEP_IDLE;
      endcase
   end

   // Loop counter advances in looping steps and wraps after the last bit.
   always_comb begin
      cnt_in = cnt_ff;
      if (cw.jump == mm64_pkg::JMP_LOOP) begin
         cnt_in = cnt_last ? '0 : cnt_ff + CNT_BITS'(1);
      end
   end

   // Reduction: shift the next dividend bit into each partial remainder, then subtract
   // the modulus if it fits. Both factors are reduced side by side.
   mm64_csub #(.WIDTH(WORD_BITS)) u_red_a (
      .sum_in  ({rem_a_ff, opa_ff[WORD_BITS-1]}),
      .mod_in  (mod_ff),
      .res_out (rem_a_nx)
   );

   mm64_csub #(.WIDTH(WORD_BITS)) u_red_b (
      .sum_in  ({rem_b_ff, opb_ff[WORD_BITS-1]}),
      .mod_in  (mod_ff),
      .res_out (rem_b_nx)
   );

   // Double-and-add: sum and doubled multiplicand, each reduced below the modulus.
   assign acc_sum = {1'b0, acc_ff} + {1'b0, opa_ff};

   mm64_csub #(.WIDTH(WORD_BITS)) u_add (
      .sum_in  (acc_sum),
      .mod_in  (mod_ff),
      .res_out (acc_nx)
   );

   mm64_csub #(.WIDTH(WORD_BITS)) u_dbl (
      .sum_in  ({opa_ff, 1'b0}),
      .mod_in  (mod_ff),
      .res_out (dbl_nx)
   );

   // Datapath operation selected by the control word.
   always_comb begin
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      rem_a_in     = rem_a_ff;
      rem_b_in     = rem_b_ff;
      acc_in       = acc_ff;
      mod_in       = mod_ff;
      tiny_in      = tiny_ff;
      rsp_valid_in = 1'b0;
      rsp_prod_in  = rsp_prod_ff;
      case (cw.op)
         mm64_pkg::OP_LOAD: begin
            // capture the beat, masked to the word width
            if (accept) begin
               opa_in   = req_factor_a[WORD_BITS-1:0];
               opb_in   = req_factor_b[WORD_BITS-1:0];
               mod_in   = req_modulus[WORD_BITS-1:0];
               tiny_in  = (req_modulus[WORD_BITS-1:1] == '0);
               rem_a_in = '0;
               rem_b_in = '0;
            end
         end
         mm64_pkg::OP_REDUCE: begin
            rem_a_in = rem_a_nx;
            rem_b_in = rem_b_nx;
            opa_in   = opa_ff << 1;
            opb_in   = opb_ff << 1;
         end
         mm64_pkg::OP_SETUP: begin
            // reduced factors become multiplicand and multiplier
            opa_in = rem_a_ff;
            opb_in = rem_b_ff;
            acc_in = '0;
         end
         mm64_pkg::OP_MULT: begin
            if (opb_ff[0]) acc_in = acc_nx;
            opa_in = dbl_nx;
            opb_in = opb_ff >> 1;
         end
         mm64_pkg::OP_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_prod_in  = tiny_ff ? '0 : acc_ff;
         end
         default: begin
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= mm64_pkg::STEP_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      opa_ff      <= opa_in;
      opb_ff      <= opb_in;
      rem_a_ff    <= rem_a_in;
      rem_b_ff    <= rem_b_in;
      acc_ff      <= acc_in;
      mod_ff      <= mod_in;
      tiny_ff     <= tiny_in;
      rsp_prod_ff <= rsp_prod_in;
   end

   // Zero-extend the result to the field width.
   always_comb begin
      rsp_product_mod                  = '0;
      rsp_product_mod[WORD_BITS-1:0]   = rsp_prod_ff;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hw/rtl/mm64_checker.sv -----
`include "modular_multiply_64_defines.svh"

module mm64_checker #(
   parameter int WORD_BITS = 64
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_valid
);

   localparam int LATENCY = 2 * WORD_BITS + 3;

   `MM64_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "busy not raised after accept")
   `MM64_ASSERT_SAME(a_rsp_when_idle, rsp_valid, !busy, "result shown while busy")
   `MM64_ASSERT_SAME(a_fall_gives_rsp, $fell(busy) && !$past(reset), rsp_valid, "no rsp at fall")
   `MM64_ASSERT_SAME(a_latency, start && !busy, ##LATENCY rsp_valid, "result latency wrong")

endmodule

bind modular_multiply_64 mm64_checker #(.WORD_BITS(WORD_BITS)) u_mm64_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid)
);

// ----- bench/tb_modular_multiply_64.sv -----
`timescale 1ns / 1ps

module tb_modular_multiply_64;

   typedef logic [mm64_pkg::FIELD_BITS-1:0] word_type;

   // One multiply request; hold_for_drain keeps it back until every product is home
   typedef struct {
      word_type factor_a;
      word_type factor_b;
      word_type modulus;
      bit       hold_for_drain;
   } mulmod_req_type;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 5;
   localparam int RANDOM_OPS    = 1630;
   localparam int IDLE_PERCENT  = 31;
   localparam int MAX_GAP       = 180;
   localparam int QUIET_FIRST   = 700;   // beats in this span are sent without gaps
   localparam int QUIET_LAST    = 1000;
   localparam int TAIL_CYCLES   = 150;   // a bit more than one item's latency
   localparam int STALL_LIMIT   = 2000;  // gap + latency + drain, taken several times over
   localparam word_type ALL_ONES  = '1;
   localparam word_type TOP_BIT   = word_type'(1) << (mm64_pkg::FIELD_BITS - 1);
   localparam word_type BIG_PRIME = 64'hFFFF_FFFF_FFFF_FFC5;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     start = 1'b0;
   logic     busy;
   word_type req_factor_a = '0;
   word_type req_factor_b = '0;
   word_type req_modulus  = '0;
   logic     rsp_valid;
   word_type rsp_product_mod;

   mulmod_req_type pending_ops[$];
   word_type       expected_products[$];
   mulmod_req_type on_port;
   int             in_flight   = 0;
   int             gap_left    = 0;
   int             beats_sent  = 0;
   int             error_count = 0;
   int             stall_count = 0;
   bit             timed_out   = 1'b0;

   modular_multiply_64 u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_factor_a    (req_factor_a),
      .req_factor_b    (req_factor_b),
      .req_modulus     (req_modulus),
      .rsp_valid       (rsp_valid),
      .rsp_product_mod (rsp_product_mod)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Product modulo m straight from a full-width multiply and a divide;
   // a modulus of zero or one gives zero.
   function automatic word_type mod_product(input word_type a, input word_type b,
                                            input word_type m);
      logic [2*mm64_pkg::FIELD_BITS-1:0] full;
      if (m <= word_type'(1)) begin
         return '0;
      end
      full = {{mm64_pkg::FIELD_BITS{1'b0}}, a} * {{mm64_pkg::FIELD_BITS{1'b0}}, b};
      return word_type'(full % {{mm64_pkg::FIELD_BITS{1'b0}}, m});
   endfunction

   function automatic word_type rand_word();
      return {$urandom, $urandom};
   endfunction

   // Skew moduli toward the corners: tiny, powers of two, near full scale
   function automatic word_type pick_modulus();
      case ($urandom_range(0, 9))
         0:       return word_type'($urandom_range(0, 17));
         1:       return word_type'(1) << $urandom_range(0, mm64_pkg::FIELD_BITS - 1);
         2:       return ALL_ONES - word_type'($urandom_range(0, 255));
         3:       return rand_word() | TOP_BIT;
         4:       return rand_word() >> $urandom_range(0, mm64_pkg::FIELD_BITS - 1);
         default: return rand_word();
      endcase
   endfunction

   // Factors around the modulus exercise the input reduction step
   function automatic word_type pick_factor(input word_type m);
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return ALL_ONES;
         2:       return m;
         3:       return m - word_type'(1);
         4:       return word_type'(1) << $urandom_range(0, mm64_pkg::FIELD_BITS - 1);
         5:       return rand_word() >> $urandom_range(0, mm64_pkg::FIELD_BITS - 1);
         6:       return m + word_type'($urandom_range(1, 3));
         default: return rand_word();
      endcase
   endfunction

   task automatic queue_op(input word_type a, input word_type b, input word_type m,
                           input bit drain);
      mulmod_req_type op;
      op.factor_a       = a;
      op.factor_b       = b;
      op.modulus        = m;
      op.hold_for_drain = drain;
      pending_ops.push_back(op);
   endtask

   // Fill the request queue, release reset, then wait for the traffic to settle
   initial begin
      word_type m;
      // directed corners: degenerate moduli, full-scale values, reduction of big factors
      queue_op('0, '0, '0, 1'b0);
      queue_op(ALL_ONES, ALL_ONES, '0, 1'b0);
      queue_op(ALL_ONES, ALL_ONES, word_type'(1), 1'b0);
      queue_op(ALL_ONES, ALL_ONES, word_type'(2), 1'b0);
      queue_op(word_type'(5), word_type'(7), word_type'(3), 1'b0);
      queue_op(ALL_ONES, ALL_ONES, ALL_ONES, 1'b0);
      queue_op(ALL_ONES - 1, ALL_ONES - 1, ALL_ONES, 1'b0);
      queue_op(ALL_ONES, ALL_ONES, TOP_BIT, 1'b0);
      queue_op(ALL_ONES, ALL_ONES, TOP_BIT + 1, 1'b0);
      queue_op(BIG_PRIME - 1, BIG_PRIME - 1, BIG_PRIME, 1'b0);
      queue_op(ALL_ONES, ALL_ONES, BIG_PRIME, 1'b0);
      queue_op(BIG_PRIME, rand_word(), BIG_PRIME, 1'b0);
      queue_op('0, ALL_ONES, BIG_PRIME, 1'b0);
      queue_op(ALL_ONES, '0, BIG_PRIME, 1'b0);
      queue_op(word_type'(1), word_type'(1), ALL_ONES, 1'b0);
      queue_op(ALL_ONES - 1, TOP_BIT, ALL_ONES, 1'b0);
      queue_op(TOP_BIT, TOP_BIT, ALL_ONES - 1, 1'b0);
      queue_op(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'hFFFF_FFFF_0000_0001,
               1'b0);
      queue_op(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h8000_0000_0000_0003,
               1'b0);
      queue_op(ALL_ONES, word_type'(1), word_type'(3), 1'b1);

      for (int i = 0; i < RANDOM_OPS; i++) begin
         m = pick_modulus();
         queue_op(pick_factor(m), pick_factor(m), m, (i % 250) == 249);
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (!timed_out && !(pending_ops.size() == 0 && in_flight == 0 && !start))
         @(posedge clock);
      if (!timed_out)
         repeat (TAIL_CYCLES) @(posedge clock);

      if (expected_products.size() != 0) begin
         $display("%0t: %0d product(s) never returned, next expected %h", $time,
                  expected_products.size(), expected_products[0]);
         error_count++;
      end
      if (timed_out)
         $display("Simulation FAILED");
      else if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Driver: present one beat, hold it until start && !busy takes it, then
   // maybe sit idle for a random gap so the next start lands on any phase of
   // the running multiply. While start is low the fields carry junk.
   always @(posedge clock) begin
      bit taken;
      if (reset) begin
         start        <= 1'b0;
         req_factor_a <= '0;
         req_factor_b <= '0;
         req_modulus  <= '0;
         in_flight    = 0;
         gap_left     = 0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            expected_products.push_back(mod_product(on_port.factor_a, on_port.factor_b,
                                                    on_port.modulus));
            in_flight++;
            beats_sent++;
            if ((beats_sent < QUIET_FIRST || beats_sent > QUIET_LAST) &&
                $urandom_range(0, 99) < IDLE_PERCENT)
               gap_left = $urandom_range(1, MAX_GAP);
         end
         // count the product leaving on this edge here, so a drain decision
         // never depends on the monitor having run first
         if (rsp_valid)
            in_flight--;

         if (start && !taken) begin
            // hold the beat steady until the block takes it
         end else if (gap_left == 0 && pending_ops.size() != 0 &&
                      !(pending_ops[0].hold_for_drain && in_flight != 0)) begin
            on_port       = pending_ops.pop_front();
            start        <= 1'b1;
            req_factor_a <= on_port.factor_a;
            req_factor_b <= on_port.factor_b;
            req_modulus  <= on_port.modulus;
         end else begin
            if (gap_left != 0)
               gap_left--;
            start        <= 1'b0;
            req_factor_a <= rand_word();
            req_factor_b <= rand_word();
            req_modulus  <= rand_word();
         end
      end
   end

   // Monitor: take every strobed product, match it against the oldest
   // expectation, and run the stall watchdog alongside.
   always @(posedge clock) begin
      word_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_products.size() == 0) begin
               $display("%0t: unexpected product, expected none, actual %h", $time,
                        rsp_product_mod);
               error_count++;
            end else begin
               want = expected_products.pop_front();
               if (rsp_product_mod !== want) begin
                  $display("%0t: product_mod mismatch, expected %h, actual %h", $time,
                           want, rsp_product_mod);
                  error_count++;
               end
            end
         end

         if ((start && !busy) || rsp_valid)
            stall_count = 0;
         else
            stall_count++;
         if (stall_count == STALL_LIMIT) begin
            $display("%0t: no beat or product for %0d cycles", $time, STALL_LIMIT);
            timed_out = 1'b1;
         end
      end
   end

endmodule
